[design/pcfk_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcfk_pkg
// Types and constants for the planar chain forward kinematics block.
// ----------------------------------------------------------------------------
package pcfk_pkg;

    localparam int ANGLE_W    = 16;
    localparam int LEN_W      = 16;
    localparam int POS_W      = 24;
    localparam int JNUM_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int Z_W        = 34;
    localparam int XY_W       = 35;
    localparam int ATAN_N     = 24;
    localparam int ATAN_IW    = 5;

    localparam logic [CFG_IDX_W-1:0] REG_JOINT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_FIRST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_LAST   = 3'd6;

    localparam logic [JNUM_W-1:0] JOINT_COUNT_RESET = 3'd3;
    localparam logic [LEN_W-1:0]  LINK_LEN_RESET    = 16'd256;

    localparam logic [31:0] KINV_Q32 = 32'h9B74EDA8;

    localparam logic signed [Z_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [Z_W-1:0] HALF_TURN    = 34'sd2147483648;
    localparam logic signed [XY_W-1:0] ROUND_HALF  = 35'sd32768;

    localparam logic [31:0] ATAN_TABLE [ATAN_N] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

endpackage : pcfk_pkg
`default_nettype wire

[design/planar_chain_forward_kinematics.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// planar_chain_forward_kinematics
// Forward kinematics of a planar revolute serial chain. Each input item is one
// joint angle. For each joint the link length is rotated by the heading held
// before the joint and added to the running frame position, then the angle is
// added to the heading. Each item yields one result item with the new frame
// position, heading, link number and a chain end mark. After the last joint of
// a chain the running state returns to the origin.
//
// The s_ channel takes joint angles and the m_ channel returns frames, both
// with valid and ready. The link lengths sit in a small synchronous memory
// written through the configuration port (cfg_index 0 is the joint count,
// 1 to 6 the link lengths); writes are to be made only while the block is
// idle, and the block itself does not enforce this. An item passes through
// these steps in order: the link memory is read as the item is accepted,
// then the gain multiply, the rotation set-up, CORDIC_STEPS iterations of a
// single shared CORDIC stage, and the final add. Because the CORDIC stage is
// shared, no new item is taken until the previous one is through; the next
// item is taken in the same cycle the previous result is loaded into the
// output register. When the receiver stalls, the result waits in the output
// register and the next item stops at its final add until the register is
// free. Reset returns the chain to the origin at the first joint, the joint
// count to 3 and all link lengths to 1.0.
// ----------------------------------------------------------------------------
module planar_chain_forward_kinematics
    import pcfk_pkg::*;
#(
    parameter int MAX_JOINTS   = 6,
    parameter int CORDIC_STEPS = 16
) (
    input  wire                         aclk,
    input  wire                         aresetn,

    input  wire                         cfg_wr_en,
    input  wire  [CFG_IDX_W-1:0]        cfg_index,
    input  wire  [CFG_DATA_W-1:0]       cfg_wr_data,

    input  wire                         s_valid,
    output logic                        s_ready,
    input  wire  signed [ANGLE_W-1:0]   s_joint_angle,

    output logic                        m_valid,
    input  wire                         m_ready,
    output logic signed [POS_W-1:0]     m_frame_x,
    output logic signed [POS_W-1:0]     m_frame_y,
    output logic signed [ANGLE_W-1:0]   m_frame_heading,
    output logic [JNUM_W-1:0]           m_link_number,
    output logic                        m_chain_end
);

    localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int SW = $clog2(CORDIC_STEPS);
    localparam logic [SW-1:0]     LAST_STEP  = SW'(CORDIC_STEPS - 1);
    localparam logic [JNUM_W-1:0] MAX_COUNT  = JNUM_W'(MAX_JOINTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_INIT,
        ST_ITER,
        ST_DONE
    } state_t;

    state_t                     state_reg;

    logic [JNUM_W-1:0]          joint_count_reg;
    logic [LEN_W-1:0]           link_mem [MAX_JOINTS];
    logic [MAX_JOINTS-1:0]      link_valid_reg;
    logic [LEN_W-1:0]           rd_data_reg;
    logic                       rd_valid_reg;

    logic [JNUM_W-1:0]          pos_reg;
    logic [ANGLE_W-1:0]         heading_reg;
    logic signed [POS_W-1:0]    run_x_reg;
    logic signed [POS_W-1:0]    run_y_reg;

    logic [ANGLE_W-1:0]         hdg_in_reg;
    logic [ANGLE_W-1:0]         hdg_out_reg;
    logic [JNUM_W-1:0]          link_num_reg;
    logic                       last_reg;

    logic [31:0]                prod_reg;
    logic signed [XY_W-1:0]     x_reg;
    logic signed [XY_W-1:0]     y_reg;
    logic signed [Z_W-1:0]      z_reg;
    logic [SW-1:0]              step_reg;

    logic                       m_valid_reg;
    logic signed [POS_W-1:0]    m_frame_x_reg;
    logic signed [POS_W-1:0]    m_frame_y_reg;
    logic [ANGLE_W-1:0]         m_heading_reg;
    logic [JNUM_W-1:0]          m_link_number_reg;
    logic                       m_chain_end_reg;

    logic                       out_free;
    logic                       accept;
    logic                       finish;
    logic [JNUM_W-1:0]          count_eff;
    logic [JNUM_W-1:0]          pos_plus;
    logic                       last_next;
    logic [CFG_IDX_W-1:0]       wr_slot;
    logic                       mem_we;
    logic [LEN_W-1:0]           len_eff;
    logic [47:0]                prod_full;
    logic signed [Z_W-1:0]      z_start;
    logic signed [XY_W-1:0]     x_start;
    logic signed [XY_W-1:0]     x_shift;
    logic signed [XY_W-1:0]     y_shift;
    logic signed [Z_W-1:0]      atan_step;
    logic signed [XY_W-1:0]     x_round;
    logic signed [XY_W-1:0]     y_round;
    logic signed [POS_W-1:0]    x_sum;
    logic signed [POS_W-1:0]    y_sum;

    // Handshake and chain bookkeeping.
    assign out_free = !m_valid_reg || m_ready;
    assign finish   = (state_reg == ST_DONE) && out_free;
    assign s_ready  = (state_reg == ST_IDLE) || finish;
    assign accept   = s_valid && s_ready;

    always_comb begin
        priority if (joint_count_reg == '0) begin
            count_eff = JNUM_W'(1);
        end else if (joint_count_reg > MAX_COUNT) begin
            count_eff = MAX_COUNT;
        end else begin
            count_eff = joint_count_reg;
        end
    end

    assign pos_plus  = pos_reg + JNUM_W'(1);
    assign last_next = pos_plus >= count_eff;

    // Link length memory, written from the configuration port.
    assign wr_slot = cfg_index - REG_LINK_FIRST;
    assign mem_we  = cfg_wr_en && (cfg_index >= REG_LINK_FIRST)
                     && (cfg_index <= REG_LINK_LAST)
                     && (32'(wr_slot) < MAX_JOINTS);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            link_mem[wr_slot[AW-1:0]] <= cfg_wr_data[LEN_W-1:0];
        end
        if (accept) begin
            rd_data_reg <= link_mem[pos_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_valid_reg  <= '0;
            joint_count_reg <= JOINT_COUNT_RESET;
            rd_valid_reg    <= 1'b0;
        end else begin
            if (mem_we) begin
                link_valid_reg[wr_slot[AW-1:0]] <= 1'b1;
            end
            if (cfg_wr_en && (cfg_index == REG_JOINT_COUNT)) begin
                joint_count_reg <= cfg_wr_data[JNUM_W-1:0];
            end
            if (accept) begin
                rd_valid_reg <= link_valid_reg[pos_reg[AW-1:0]];
            end
        end
    end

    assign len_eff   = rd_valid_reg ? rd_data_reg : LINK_LEN_RESET;
    assign prod_full = 48'(len_eff) * 48'(KINV_Q32);

    // Quadrant fold of the start angle.
    always_comb begin
        z_start = Z_W'($signed(hdg_in_reg)) <<< 16;
        x_start = $signed({{(XY_W-32){1'b0}}, prod_reg});
        priority if (z_start > QUARTER_TURN) begin
            z_start = z_start - HALF_TURN;
            x_start = -x_start;
        end else if (z_start < -QUARTER_TURN) begin
            z_start = z_start + HALF_TURN;
            x_start = -x_start;
        end else begin
            x_start = x_start;
        end
    end

    assign x_shift   = x_reg >>> step_reg;
    assign y_shift   = y_reg >>> step_reg;
    assign atan_step = $signed(Z_W'(ATAN_TABLE[ATAN_IW'(step_reg)]));

    assign x_round = (x_reg + ROUND_HALF) >>> 16;
    assign y_round = (y_reg + ROUND_HALF) >>> 16;
    assign x_sum   = run_x_reg + x_round[POS_W-1:0];
    assign y_sum   = run_y_reg + y_round[POS_W-1:0];

    // Sequencer, running chain state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            heading_reg <= '0;
            run_x_reg   <= '0;
            run_y_reg   <= '0;
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
        end else begin
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (accept) begin
                hdg_in_reg   <= heading_reg;
                hdg_out_reg  <= heading_reg + s_joint_angle;
                link_num_reg <= pos_plus;
                last_reg     <= last_next;
                heading_reg  <= last_next ? '0 : heading_reg + s_joint_angle;
                pos_reg      <= last_next ? '0 : pos_plus;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= prod_full[47:16];
                    state_reg <= ST_INIT;
                end
                ST_INIT: begin
                    x_reg     <= x_start;
                    y_reg     <= '0;
                    z_reg     <= z_start;
                    step_reg  <= '0;
                    state_reg <= ST_ITER;
                end
                ST_ITER: begin
                    if (!z_reg[Z_W-1]) begin
                        x_reg <= x_reg - y_shift;
                        y_reg <= y_reg + x_shift;
                        z_reg <= z_reg - atan_step;
                    end else begin
                        x_reg <= x_reg + y_shift;
                        y_reg <= y_reg - x_shift;
                        z_reg <= z_reg + atan_step;
                    end
                    step_reg <= step_reg + SW'(1);
                    if (step_reg == LAST_STEP) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (finish) begin
                        m_frame_x_reg     <= x_sum;
                        m_frame_y_reg     <= y_sum;
                        m_heading_reg     <= hdg_out_reg;
                        m_link_number_reg <= link_num_reg;
                        m_chain_end_reg   <= last_reg;
                        run_x_reg         <= last_reg ? '0 : x_sum;
                        run_y_reg         <= last_reg ? '0 : y_sum;
                        state_reg         <= accept ? ST_MUL : ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_frame_x       = m_frame_x_reg;
    assign m_frame_y       = m_frame_y_reg;
    assign m_frame_heading = $signed(m_heading_reg);
    assign m_link_number   = m_link_number_reg;
    assign m_chain_end     = m_chain_end_reg;

    // A stalled result holds the finished item back in its final stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_valid_reg && !m_ready) |=> (state_reg == ST_DONE))
        else $error("finished item left the final stage while the output was stalled");

    // The end of a chain returns the running state to the origin.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && last_next) |=> (pos_reg == '0 && heading_reg == '0))
        else $error("chain state not cleared after the last joint");

    // The joint position never leaves the link memory.
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(pos_reg) < MAX_JOINTS)
        else $error("joint position beyond the last link");

    // Result link numbers stay within the chain.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_link_number_reg != '0 && 32'(m_link_number_reg) <= MAX_JOINTS))
        else $error("result link number out of range");

endmodule : planar_chain_forward_kinematics
`default_nettype wire

[test/planar_chain_forward_kinematics_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_chain_forward_kinematics_tb
// Self-checking bench for the planar chain forward kinematics block. Joint
// angles go in over the s_ channel while a bit-accurate fixed-point CORDIC
// predictor tracks the running frame of the chain. Every frame returned on the
// m_ channel is compared field by field with the oldest prediction. Directed
// tests cover angle and link length extremes, quarter turn boundaries and the
// joint count corner cases, then random traffic runs under changing chain
// setups with the sender and the receiver stalling in turn.
// ----------------------------------------------------------------------------
module planar_chain_forward_kinematics_tb;
    import pcfk_pkg::*;

    localparam int MAX_JOINTS   = 6;
    localparam int CORDIC_STEPS = 16;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [63:0] GAIN_INV_Q32 = 64'h9B74EDA8;
    localparam longint QUARTER_UNITS = 64'sd1073741824;
    localparam longint HALF_UNITS    = 64'sd2147483648;

    typedef struct {
        logic signed [POS_W-1:0]   x;
        logic signed [POS_W-1:0]   y;
        logic signed [ANGLE_W-1:0] heading;
        logic [JNUM_W-1:0]         link;
        logic                      last;
    } frame_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [ANGLE_W-1:0] s_joint_angle = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [POS_W-1:0] m_frame_x;
    logic signed [POS_W-1:0] m_frame_y;
    logic signed [ANGLE_W-1:0] m_frame_heading;
    logic [JNUM_W-1:0] m_link_number;
    logic m_chain_end;

    // Predictor copy of the chain state and its setup.
    logic [JNUM_W-1:0] chain_len = JOINT_COUNT_RESET;
    logic [LEN_W-1:0] link_len [MAX_JOINTS] = '{default: LINK_LEN_RESET};
    logic [JNUM_W-1:0] joint_idx = '0;
    logic [ANGLE_W-1:0] heading_acc = '0;
    logic signed [POS_W-1:0] pos_x = '0;
    logic signed [POS_W-1:0] pos_y = '0;

    longint turn_atan [CORDIC_STEPS] = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C
    };

    frame_t frames_due [$];
    frame_t want;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int items_sent = 0;
    int frames_checked = 0;
    int config_sets = 0;

    planar_chain_forward_kinematics #(
        .MAX_JOINTS  (MAX_JOINTS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_joint_angle  (s_joint_angle),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_x      (m_frame_x),
        .m_frame_y      (m_frame_y),
        .m_frame_heading(m_frame_heading),
        .m_link_number  (m_link_number),
        .m_chain_end    (m_chain_end)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d frames still pending.", frames_due.size());
        $display("Regression FAIL");
        $finish;
    end

    function automatic frame_t predict_frame(logic [ANGLE_W-1:0] angle);
        longint z, x, y, xs, ys, dx, dy;
        logic [63:0] prod;
        int cnt, pos;
        frame_t f;
        cnt = chain_len;
        if (cnt < 1) cnt = 1;
        if (cnt > MAX_JOINTS) cnt = MAX_JOINTS;
        pos = joint_idx;
        if (pos > MAX_JOINTS - 1) pos = MAX_JOINTS - 1;

        z = longint'($signed(heading_acc)) * 65536;
        prod = 64'(link_len[pos]) * GAIN_INV_Q32;
        x = $signed(prod >> 16);
        y = 0;
        if (z > QUARTER_UNITS) begin
            z = z - HALF_UNITS;
            x = -x;
        end else if (z < -QUARTER_UNITS) begin
            z = z + HALF_UNITS;
            x = -x;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - turn_atan[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + turn_atan[i];
            end
        end
        dx = (x + 32768) >>> 16;
        dy = (y + 32768) >>> 16;

        pos_x = pos_x + dx[POS_W-1:0];
        pos_y = pos_y + dy[POS_W-1:0];
        heading_acc = heading_acc + angle;
        f.x = pos_x;
        f.y = pos_y;
        f.heading = heading_acc;
        f.link = JNUM_W'(pos + 1);
        f.last = (pos + 1 >= cnt);
        if (f.last) begin
            joint_idx = '0;
            heading_acc = '0;
            pos_x = '0;
            pos_y = '0;
        end else begin
            joint_idx = JNUM_W'(pos + 1);
        end
        return f;
    endfunction

    task automatic report_mismatch(string what, int got, int exp_val);
        $display("MISMATCH frame %0d %s: got %0d, expected %0d at %0t",
                 frames_checked, what, got, exp_val, $time);
        mismatches++;
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (frames_due.size() == 0) begin
                report_mismatch("with no item pending, x", int'(m_frame_x), 0);
            end else begin
                want = frames_due.pop_front();
                if (m_frame_x !== want.x)
                    report_mismatch("frame_x", int'(m_frame_x), int'(want.x));
                if (m_frame_y !== want.y)
                    report_mismatch("frame_y", int'(m_frame_y), int'(want.y));
                if (m_frame_heading !== want.heading)
                    report_mismatch("frame_heading", int'(m_frame_heading),
                                    int'(want.heading));
                if (m_link_number !== want.link)
                    report_mismatch("link_number", int'(m_link_number), int'(want.link));
                if (m_chain_end !== want.last)
                    report_mismatch("chain_end", int'(m_chain_end), int'(want.last));
                frames_checked++;
            end
        end
    end

    task automatic send_angle(logic [ANGLE_W-1:0] angle);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_joint_angle <= angle;
        do @(posedge aclk); while (!s_ready);
        frames_due.push_back(predict_frame(angle));
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (frames_due.size() != 0) @(negedge aclk);
        repeat (CORDIC_STEPS + 4) @(negedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        if (idx == REG_JOINT_COUNT) begin
            chain_len = data[JNUM_W-1:0];
        end else if (idx >= REG_LINK_FIRST && idx <= REG_LINK_LAST) begin
            link_len[idx - REG_LINK_FIRST] = data;
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic test_default_chain();
        send_angle(16'h0000);
        send_angle(16'h2000);
        send_angle(16'hE000);
    endtask

    task automatic test_quarter_turns();
        wait_drain();
        cfg_write(REG_JOINT_COUNT, 16'd6);
        cfg_write(CFG_IDX_W'(REG_LINK_FIRST + 0), 16'h0100);
        cfg_write(CFG_IDX_W'(REG_LINK_FIRST + 1), 16'h0A80);
        cfg_write(CFG_IDX_W'(REG_LINK_FIRST + 2), 16'h3000);
        cfg_write(CFG_IDX_W'(REG_LINK_FIRST + 3), 16'h0001);
        cfg_write(CFG_IDX_W'(REG_LINK_FIRST + 4), 16'h7FFF);
        cfg_write(CFG_IDX_W'(REG_LINK_FIRST + 5), 16'h0200);
        // Headings before the joints land on and just past both quarter turns.
        send_angle(16'h4000);
        send_angle(16'h0001);
        send_angle(16'h8000);
        send_angle(16'hFFFF);
        send_angle(16'hFFFF);
        send_angle(16'h7FFF);
    endtask

    task automatic test_link_extremes();
        wait_drain();
        for (int k = 0; k < MAX_JOINTS; k++) begin
            cfg_write(CFG_IDX_W'(REG_LINK_FIRST + k), (k == 1 || k == 4) ? 16'h0000 : 16'hFFFF);
        end
        send_angle(16'h7FFF);
        send_angle(16'h8000);
        send_angle(16'h5555);
        send_angle(16'hAAAB);
        send_angle(16'h2EE0);
        send_angle(16'h0000);
    endtask

    task automatic test_count_limits();
        wait_drain();
        // A count of zero acts as a single joint, seven acts as six.
        cfg_write(REG_JOINT_COUNT, 16'hFFF8);
        send_angle(16'h1234);
        send_angle(16'hEDCB);
        wait_drain();
        cfg_write(REG_JOINT_COUNT, 16'hFFFF);
        repeat (MAX_JOINTS) send_angle(16'h1555);
    endtask

    task automatic test_count_lowered();
        wait_drain();
        cfg_write(REG_JOINT_COUNT, 16'd6);
        send_angle(16'h3000);
        send_angle(16'hC800);
        send_angle(16'h0400);
        wait_drain();
        // The chain is past the new count, so the next joint closes it.
        cfg_write(REG_JOINT_COUNT, 16'd2);
        cfg_write(REG_UNUSED, 16'hFFFF);
        send_angle(16'h0800);
        send_angle(16'h0100);
        send_angle(16'h0200);
    endtask

    task automatic test_random_traffic(int n_items);
        int first, block, r, k;
        logic [LEN_W-1:0] len;
        logic [ANGLE_W-1:0] angle;
        first = items_sent;
        while (items_sent - first < n_items) begin
            wait_drain();
            cfg_write(REG_JOINT_COUNT, CFG_DATA_W'($urandom));
            for (k = 0; k < MAX_JOINTS; k++) begin
                r = $urandom_range(9);
                len = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : LEN_W'($urandom);
                cfg_write(CFG_IDX_W'(REG_LINK_FIRST + k), len);
            end
            if ($urandom_range(3) == 0) cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
            config_sets++;
            block = $urandom_range(10, 60);
            repeat (block) begin
                if (items_sent - first < n_items) begin
                    if ($urandom_range(29) == 0) wait_drain();
                    if ($urandom_range(9) < 3) begin
                        case ($urandom_range(7))
                            0: angle = 16'h0000;
                            1: angle = 16'h4000;
                            2: angle = 16'h4001;
                            3: angle = 16'hC000;
                            4: angle = 16'hBFFF;
                            5: angle = 16'h7FFF;
                            6: angle = 16'h8000;
                            default: angle = 16'h0001;
                        endcase
                    end else begin
                        angle = ANGLE_W'($urandom);
                    end
                    send_angle(angle);
                end
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 30;
        stall_pct = 82;
        test_default_chain();
        test_quarter_turns();
        test_link_extremes();
        test_count_limits();
        test_count_lowered();
        test_random_traffic(280);

        send_idle_pct = 82;
        stall_pct = 30;
        test_random_traffic(285);

        send_idle_pct = 0;
        stall_pct = 0;
        test_random_traffic(285);

        wait_drain();
        $display("Sent %0d joint angles and checked %0d frames over %0d random chain setups.",
                 items_sent, frames_checked, config_sets);
        $display("Covered joint counts 0 to 7, link lengths 0 to 65535 and every heading quadrant.");
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
design/pcfk_pkg.sv
design/planar_chain_forward_kinematics.sv
test/planar_chain_forward_kinematics_tb.sv
